// ===== hdl/dqr_pkg.sv =====
// Shared types, codes and defaults for the deque with remove-by-value.
package dqr_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE     = 3'd4;
  localparam logic [2:0] OP_LIST       = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_LIST
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_RIGHT,
    CMD_WRITE_BACK,
    CMD_SHIFT_LEFT,
    CMD_COMPARE,
    CMD_DROP,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               element_valid;
    logic [4:0]         count;
    status_t            status;
    logic               last;
  } out_t;

endpackage

// ===== hdl/dqr_cell.sv =====
// One storage cell of the deque chain: holds an entry and its match flag.
module dqr_cell
  import dqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  cell_ctl_t                        ctl,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic signed [31:0]               left_val,
  input  logic signed [31:0]               right_val,
  input  logic signed [31:0]               front_val,
  input  logic                             seen_in,
  output logic signed [31:0]               val,
  output logic                             seen_out
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic signed [31:0] val_r, val_nxt;
  logic               match_r, match_nxt;

  assign val      = val_r;
  assign seen_out = seen_in | match_r;

  always_comb begin
    val_nxt   = val_r;
    match_nxt = match_r;
    unique case (ctl.cmd)
      CMD_HOLD: ;
      CMD_SHIFT_RIGHT: val_nxt = left_val;
      CMD_WRITE_BACK: begin
        if (IdxC == count) begin
          val_nxt = ctl.key;
        end
      end
      CMD_SHIFT_LEFT: val_nxt = right_val;
      CMD_COMPARE: match_nxt = (val_r == ctl.key) && (IdxC < count);
      CMD_DROP: begin
        if (seen_out) begin
          val_nxt = right_val;
        end
      end
      CMD_ROTATE: begin
        if (IdxC + CW'(1) == count) begin
          val_nxt = front_val;
        end else begin
          val_nxt = right_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= match_nxt;
  end

endmodule

// ===== hdl/deque_with_remove_by_value_core.sv =====
// Top level of the bounded deque with remove-by-value, built as a cell chain.
//
// Push front, push back, pop front, pop back and unused codes give one result per request.
// For a remove on a non-empty deque, every cell compares its entry with the value, and in
// the next cycle the first match and all cells behind it shift toward the front, the first
// match found through a one-bit chain across the cells. List gives one result per entry, front
// first, one per cycle while the consumer takes them, by rotating the chain once around; an
// empty list gives a single result. Results pass through a single output register, and a new
// request is taken once the block is idle and that register is free or being emptied.
module deque_with_remove_by_value_core
  import dqr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              out_valid_r;
  out_t              out_data_r;
  out_t              res;
  logic              load;
  logic              slot_free;
  logic              in_fire;
  logic              full;
  logic              empty;
  cell_ctl_t         ctl;

  logic signed [31:0] cell_val [DEPTH];
  logic               seen [DEPTH+1];

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign seen[0]   = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqr_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .left_val ((i == 0) ? ctl.key : cell_val[(i == 0) ? 0 : i-1]),
      .right_val(cell_val[(i == DEPTH-1) ? i : i+1]),
      .front_val(cell_val[0]),
      .seen_in  (seen[i]),
      .val      (cell_val[i]),
      .seen_out (seen[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !empty && in_data.op == OP_REMOVE) begin
          state_nxt = ST_DROP;
        end else if (in_fire && !empty && in_data.op == OP_LIST) begin
          state_nxt = ST_LIST;
        end
      end
      ST_DROP: state_nxt = ST_IDLE;
      ST_LIST: begin
        if (slot_free && (CW'(idx_r) + CW'(1) == count_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd           = CMD_HOLD;
    ctl.key           = in_data.value;
    count_nxt         = count_r;
    idx_nxt           = idx_r;
    load              = 1'b0;
    res.element       = '0;
    res.element_valid = 1'b0;
    res.status        = STAT_OK;
    res.last          = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          unique case (in_data.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.cmd   = CMD_SHIFT_RIGHT;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ctl.cmd   = CMD_WRITE_BACK;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                ctl.cmd   = CMD_SHIFT_LEFT;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                ctl.cmd = CMD_COMPARE;
                load    = 1'b0;
              end
            end
            OP_LIST: begin
              if (!empty) begin
                idx_nxt = '0;
                load    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DROP: begin
        ctl.cmd = CMD_DROP;
        load    = 1'b1;
        if (seen[DEPTH]) begin
          count_nxt = count_r - CW'(1);
        end else begin
          res.status = STAT_NOTFOUND;
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          ctl.cmd           = CMD_ROTATE;
          load              = 1'b1;
          res.element       = cell_val[0];
          res.element_valid = 1'b1;
          res.last          = (CW'(idx_r) + CW'(1) == count_r);
          idx_nxt           = idx_r + IW'(1);
        end
      end
      default: ;
    endcase
    res.count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_remove_enters_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !empty && in_data.op == OP_REMOVE) |=> state_r == ST_DROP)
    else $error("remove request did not enter the drop phase");

  a_list_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |=> $stable(count_r))
    else $error("entry count changed while listing");

  a_result_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result loaded over one not yet taken");

endmodule
